>>> rtl/core/hkbd_pkg.sv
package hkbd_pkg;

	// Report geometry
	localparam int KEY_SLOTS  = 6;
	localparam int CODE_W     = 8;
	localparam int MOD_BITS   = 8;
	localparam int NUM_EVENTS = MOD_BITS + 2 * KEY_SLOTS;
	localparam int EV_IDX_W   = $clog2(NUM_EVENTS);

	// Event slot layout: modifiers, then releases, then presses
	localparam int REL_BASE = MOD_BITS;
	localparam int PRS_BASE = MOD_BITS + KEY_SLOTS;

	localparam logic [CODE_W-1:0] MOD_BASE_CODE = 8'hE0;
	localparam logic [CODE_W-1:0] EMPTY_CODE    = 8'h00;

	typedef struct packed {
		logic [MOD_BITS-1:0]                mods;
		logic [KEY_SLOTS-1:0][CODE_W-1:0]   slots;
	} report_t;

	typedef struct packed {
		logic [CODE_W-1:0] key_code;
		logic              pressed;
		logic              last_event;
	} event_t;

	// Controller to datapath
	typedef struct packed {
		logic load_report;
		logic eval;
		logic pop;
		logic upd_old;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic mask_empty;
		logic out_free;
	} dp_status_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EVAL = 3'b010,
		S_EMIT = 3'b100
	} state_t;

endpackage

>>> rtl/core/hkbd_if.sv
interface hkbd_report_if;
	logic       valid;
	logic       ready;
	logic [7:0] new_modifiers;
	logic [7:0] key_slot_0;
	logic [7:0] key_slot_1;
	logic [7:0] key_slot_2;
	logic [7:0] key_slot_3;
	logic [7:0] key_slot_4;
	logic [7:0] key_slot_5;

	modport source (
		output valid, new_modifiers, key_slot_0, key_slot_1, key_slot_2,
		       key_slot_3, key_slot_4, key_slot_5,
		input  ready
	);
	modport sink (
		input  valid, new_modifiers, key_slot_0, key_slot_1, key_slot_2,
		       key_slot_3, key_slot_4, key_slot_5,
		output ready
	);
endinterface

interface hkbd_event_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_code;
	logic       pressed;
	logic       last_event;

	modport source (
		output valid, key_code, pressed, last_event,
		input  ready
	);
	modport sink (
		input  valid, key_code, pressed, last_event,
		output ready
	);
endinterface

>>> rtl/core/hkbd_ctrl.sv
module hkbd_ctrl
	import hkbd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;

	// Sequence one report: capture, evaluate, drain events, commit
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_report = 1'b1;
					state_d         = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				if (status.mask_empty) begin
					cmd.upd_old = 1'b1;
					state_d     = S_IDLE;
				end else if (status.out_free) begin
					cmd.pop = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/hkbd_dp.sv
module hkbd_dp
	import hkbd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  report_t    report,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	output logic       out_valid,
	input  logic       out_ready,
	output event_t     out_event
);

	report_t                  new_q;
	report_t                  old_q;
	logic [NUM_EVENTS-1:0]    mask_q;
	logic                     out_valid_q;
	event_t                   out_q;

	logic [NUM_EVENTS-1:0]    mask_d;
	logic [NUM_EVENTS-1:0]    first_oh;
	logic [NUM_EVENTS-1:0]    mask_rest;
	logic [CODE_W-1:0]        ev_code [NUM_EVENTS];
	logic [NUM_EVENTS-1:0]    ev_press;
	event_t                   next_event;
	logic                     in_new;
	logic                     in_old;

	// Build the change mask: modifier toggles, missing old keys, new keys
	always_comb begin
		mask_d = '0;
		for (int m = 0; m < MOD_BITS; m++) begin
			mask_d[m] = new_q.mods[m] ^ old_q.mods[m];
		end
		for (int j = 0; j < KEY_SLOTS; j++) begin
			in_new = 1'b0;
			in_old = 1'b0;
			for (int k = 0; k < KEY_SLOTS; k++) begin
				in_new = in_new | (new_q.slots[k] == old_q.slots[j]);
				in_old = in_old | (old_q.slots[k] == new_q.slots[j]);
			end
			mask_d[REL_BASE + j] = (old_q.slots[j] != EMPTY_CODE) && !in_new;
			mask_d[PRS_BASE + j] = (new_q.slots[j] != EMPTY_CODE) && !in_old;
		end
	end

	// Code and direction of each event position
	always_comb begin
		for (int m = 0; m < MOD_BITS; m++) begin
			ev_code[m]  = MOD_BASE_CODE + CODE_W'(m);
			ev_press[m] = new_q.mods[m];
		end
		for (int j = 0; j < KEY_SLOTS; j++) begin
			ev_code[REL_BASE + j]  = old_q.slots[j];
			ev_press[REL_BASE + j] = 1'b0;
			ev_code[PRS_BASE + j]  = new_q.slots[j];
			ev_press[PRS_BASE + j] = 1'b1;
		end
	end

	// Pick the lowest pending event
	assign first_oh  = mask_q & (~mask_q + NUM_EVENTS'(1));
	assign mask_rest = mask_q & ~first_oh;

	always_comb begin
		next_event            = '0;
		for (int i = 0; i < NUM_EVENTS; i++) begin
			next_event.key_code = next_event.key_code | ({CODE_W{first_oh[i]}} & ev_code[i]);
			next_event.pressed  = next_event.pressed | (first_oh[i] & ev_press[i]);
		end
		next_event.last_event = (mask_rest == '0);
	end

	assign status.mask_empty = (mask_q == '0);
	assign status.out_free   = !out_valid_q || out_ready;
	assign out_valid         = out_valid_q;
	assign out_event         = out_q;

	// Hold the incoming report
	always_ff @(posedge clk) begin
		if (cmd.load_report) begin
			new_q <= report;
		end
	end

	// Commit the report as the previous one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_q <= '0;
		end else if (cmd.upd_old) begin
			old_q <= new_q;
		end
	end

	// Load or drain the pending event mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cmd.eval) begin
			mask_q <= mask_d;
		end else if (cmd.pop) begin
			mask_q <= mask_rest;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			out_q <= next_event;
		end
	end

endmodule

>>> rtl/core/hid_keyboard_report_to_key_events_unit.sv
// Channel  Role   Payload
// rpt      sink   new_modifiers, key_slot_0 .. key_slot_5
// evt      source key_code, pressed, last_event
//
// A report is handled in steps: capture it, build the change mask, pass each
// event through the output register, then commit it as the previous report.
// The mask drains one event per cycle while the event channel is not stalled.
// Reset clears the previous report to all zero. A stalled event channel holds
// the output register and pauses the drain; a new report waits until the
// current one has committed.
module hid_keyboard_report_to_key_events_unit
	import hkbd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	hkbd_report_if.sink  rpt,
	hkbd_event_if.source evt
);

	report_t    report;
	dp_cmd_t    cmd;
	dp_status_t status;
	event_t     out_event;
	logic       in_ready;

	// Gather report fields
	always_comb begin
		report.mods     = rpt.new_modifiers;
		report.slots[0] = rpt.key_slot_0;
		report.slots[1] = rpt.key_slot_1;
		report.slots[2] = rpt.key_slot_2;
		report.slots[3] = rpt.key_slot_3;
		report.slots[4] = rpt.key_slot_4;
		report.slots[5] = rpt.key_slot_5;
	end

	assign rpt.ready      = in_ready;
	assign evt.key_code   = out_event.key_code;
	assign evt.pressed    = out_event.pressed;
	assign evt.last_event = out_event.last_event;

	hkbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rpt.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	hkbd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.report    (report),
		.cmd       (cmd),
		.status    (status),
		.out_valid (evt.valid),
		.out_ready (evt.ready),
		.out_event (out_event)
	);

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import hkbd_pkg::*;

	logic clk = 1'b0;
	logic arst_n;

	hkbd_report_if rpt_if ();
	hkbd_event_if  evt_if ();

	hid_keyboard_report_to_key_events_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rpt    (rpt_if),
		.evt    (evt_if)
	);

	// Per-side idle enables, switched between test phases
	bit src_throttle = 1'b0;
	bit snk_throttle = 1'b0;

	// Stored report as the block should hold it, and the events still owed
	report_t held_report = '0;
	event_t  key_events_due[$];

	int unsigned mismatch_count = 0;
	int unsigned evt_hold = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Count a failure; show only the first few
	function automatic void flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
	endfunction

	function automatic report_t make_report(input logic [7:0] m, input logic [7:0] s0,
		input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] s3,
		input logic [7:0] s4, input logic [7:0] s5);
		report_t r;
		r.mods     = m;
		r.slots[0] = s0;
		r.slots[1] = s1;
		r.slots[2] = s2;
		r.slots[3] = s3;
		r.slots[4] = s4;
		r.slots[5] = s5;
		return r;
	endfunction

	function automatic bit report_holds(input report_t r, input logic [CODE_W-1:0] code);
		for (int s = 0; s < KEY_SLOTS; s++) begin
			if (r.slots[s] == code) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void push_key_event(input logic [CODE_W-1:0] code, input logic down);
		event_t ev;
		ev.key_code   = code;
		ev.pressed    = down;
		ev.last_event = 1'b0;
		key_events_due.push_back(ev);
	endfunction

	// Diff the accepted report against the held one, queue the events, then commit it
	function automatic void predict_key_events(input report_t nxt);
		logic [MOD_BITS-1:0] mods_up;
		logic [MOD_BITS-1:0] mods_down;
		int unsigned         first;
		event_t              tail;
		first     = key_events_due.size();
		mods_up   = held_report.mods & ~nxt.mods;
		mods_down = nxt.mods & ~held_report.mods;
		for (int b = 0; b < MOD_BITS; b++) begin
			if (mods_up[b]) begin
				push_key_event(MOD_BASE_CODE + CODE_W'(b), 1'b0);
			end
			if (mods_down[b]) begin
				push_key_event(MOD_BASE_CODE + CODE_W'(b), 1'b1);
			end
		end
		for (int s = 0; s < KEY_SLOTS; s++) begin
			if (held_report.slots[s] != EMPTY_CODE && !report_holds(nxt, held_report.slots[s])) begin
				push_key_event(held_report.slots[s], 1'b0);
			end
		end
		for (int s = 0; s < KEY_SLOTS; s++) begin
			if (nxt.slots[s] != EMPTY_CODE && !report_holds(held_report, nxt.slots[s])) begin
				push_key_event(nxt.slots[s], 1'b1);
			end
		end
		// Mark the final event of this report
		if (key_events_due.size() > first) begin
			tail = key_events_due.pop_back();
			tail.last_event = 1'b1;
			key_events_due.push_back(tail);
		end
		held_report = nxt;
	endfunction

	// Compare one event transaction with the oldest one owed
	task automatic check_key_event();
		event_t want;
		if (key_events_due.size() == 0) begin
			flag_mismatch($sformatf("unexpected event key_code=%02h pressed=%0b last_event=%0b",
				evt_if.key_code, evt_if.pressed, evt_if.last_event));
		end else begin
			want = key_events_due.pop_front();
			if (evt_if.key_code !== want.key_code) begin
				flag_mismatch($sformatf("key_code expected %02h, got %02h",
					want.key_code, evt_if.key_code));
			end
			if (evt_if.pressed !== want.pressed) begin
				flag_mismatch($sformatf("pressed for %02h expected %0b, got %0b",
					want.key_code, want.pressed, evt_if.pressed));
			end
			if (evt_if.last_event !== want.last_event) begin
				flag_mismatch($sformatf("last_event for %02h expected %0b, got %0b",
					want.key_code, want.last_event, evt_if.last_event));
			end
		end
	endtask

	// Event sink: check each transaction, then stall for a random count when enabled
	always @(posedge clk) begin
		if (!arst_n) begin
			evt_if.ready <= 1'b0;
		end else begin
			if (evt_if.valid === 1'b1 && evt_if.ready === 1'b1) begin
				check_key_event();
				evt_hold = snk_throttle ? $urandom_range(0, 14) : 0;
			end
			if (evt_hold != 0) begin
				evt_hold--;
				evt_if.ready <= 1'b0;
			end else begin
				evt_if.ready <= 1'b1;
			end
		end
	end

	// Offer one report, hold it until accepted, then predict its events
	task automatic send_report(input report_t r);
		int unsigned gap;
		gap = src_throttle ? $urandom_range(0, 14) : 0;
		if (gap != 0) begin
			rpt_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rpt_if.valid         <= 1'b1;
		rpt_if.new_modifiers <= r.mods;
		rpt_if.key_slot_0    <= r.slots[0];
		rpt_if.key_slot_1    <= r.slots[1];
		rpt_if.key_slot_2    <= r.slots[2];
		rpt_if.key_slot_3    <= r.slots[3];
		rpt_if.key_slot_4    <= r.slots[4];
		rpt_if.key_slot_5    <= r.slots[5];
		do @(posedge clk); while (rpt_if.ready !== 1'b1);
		predict_key_events(r);
	endtask

	// Mostly ordinary usage codes from a narrow pool so duplicates show up
	function automatic logic [7:0] pick_code();
		if ($urandom_range(0, 3) == 0) begin
			return 8'($urandom);
		end
		return 8'($urandom_range(8'h04, 8'h0C));
	endfunction

	// Apply one plausible keystroke change to a report
	function automatic report_t next_keystroke(input report_t cur);
		report_t     nxt;
		int unsigned a;
		int unsigned b;
		logic [7:0]  t;
		nxt = cur;
		a = $urandom_range(0, KEY_SLOTS - 1);
		b = $urandom_range(0, KEY_SLOTS - 1);
		case ($urandom_range(0, 5))
			0, 1: begin
				nxt.slots[a] = pick_code();
			end
			2: begin
				nxt.slots[a] = EMPTY_CODE;
			end
			3: begin
				nxt.mods = nxt.mods ^ (8'h01 << $urandom_range(0, 7));
			end
			4: begin
				nxt.mods = 8'($urandom);
				nxt.slots[a] = pick_code();
			end
			default: begin
				t = nxt.slots[a];
				nxt.slots[a] = nxt.slots[b];
				nxt.slots[b] = t;
			end
		endcase
		return nxt;
	endfunction

	// Field extremes, unchanged reports, duplicates, modifier codes in slots, full event load
	task automatic test_directed();
		src_throttle = 1'b0;
		snk_throttle = 1'b0;
		send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_report(make_report(8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_report(make_report(8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_report(make_report(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04));
		send_report(make_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_report(make_report(8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_report(make_report(8'h00, 8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE7, 8'h01));
		send_report(make_report(8'h55, 8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE7, 8'h01));
		send_report(make_report(8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_report(make_report(8'h00, 8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h02));
		send_report(make_report(8'h00, 8'h7F, 8'hBF, 8'hDF, 8'hEF, 8'hF7, 8'hFD));
		send_report(make_report(8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06));
		send_report(make_report(8'h00, 8'h11, 8'h11, 8'h22, 8'h22, 8'h00, 8'h00));
		send_report(make_report(8'h00, 8'h11, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
	endtask

	// Realistic typing: each report a few keystrokes away from the last
	task automatic test_typing(input int unsigned count);
		report_t r;
		src_throttle = 1'b1;
		snk_throttle = 1'b1;
		repeat (count) begin
			r = held_report;
			repeat ($urandom_range(1, 3)) begin
				r = next_keystroke(r);
			end
			send_report(r);
		end
	endtask

	// Back-to-back typing with both sides running flat out
	task automatic test_burst(input int unsigned count);
		src_throttle = 1'b0;
		snk_throttle = 1'b0;
		repeat (count) begin
			send_report(next_keystroke(held_report));
		end
	endtask

	// Unrelated random reports, about a third of the slots empty
	task automatic test_noise(input int unsigned count);
		report_t r;
		src_throttle = 1'b1;
		snk_throttle = 1'b1;
		repeat (count) begin
			r.mods = 8'($urandom);
			for (int s = 0; s < KEY_SLOTS; s++) begin
				r.slots[s] = ($urandom_range(0, 2) == 0) ? EMPTY_CODE : 8'($urandom);
			end
			send_report(r);
		end
	endtask

	// Drain the owed events, let the block commit, then give the verdict
	task automatic finish_run();
		rpt_if.valid <= 1'b0;
		while (key_events_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (30) @(posedge clk);
		if (key_events_due.size() != 0) begin
			flag_mismatch($sformatf("%0d events never arrived", key_events_due.size()));
		end
		if (mismatch_count == 0) begin
			$display("** hid_keyboard_report_to_key_events_unit: PASSED **");
		end else begin
			$display("** hid_keyboard_report_to_key_events_unit: FAILED **");
		end
		$finish;
	endtask

	initial begin
		arst_n               <= 1'b0;
		rpt_if.valid         <= 1'b0;
		rpt_if.new_modifiers <= 8'h00;
		rpt_if.key_slot_0    <= 8'h00;
		rpt_if.key_slot_1    <= 8'h00;
		rpt_if.key_slot_2    <= 8'h00;
		rpt_if.key_slot_3    <= 8'h00;
		rpt_if.key_slot_4    <= 8'h00;
		rpt_if.key_slot_5    <= 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_typing(50);
		test_burst(25);
		test_noise(20);
		test_typing(15);
		finish_run();
	end

	// Hard stop if the handshakes hang
	initial begin
		#5_000_000;
		$display("** hid_keyboard_report_to_key_events_unit: FAILED **");
		$finish;
	end

endmodule
